[hdl/cle_pkg.sv]
package cle_pkg;

  // received item
  typedef struct packed {
    logic       op;
    logic [7:0] char_in;
    logic       first_of_read;
  } cle_in_t;

  // result item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       line_ready;
    logic       last;
  } cle_out_t;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] K_ECHO  = 3'd0;
  localparam logic [2:0] K_ERASE = 3'd1;
  localparam logic [2:0] K_DATA  = 3'd2;
  localparam logic [2:0] K_EOF   = 3'd3;
  localparam logic [2:0] K_EMPTY = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_NONE   = 8'hff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_RD_EMIT,
    ST_KILL_CHK,
    ST_KILL_WAIT,
    ST_KILL_EVAL
  } cle_state_t;

endpackage

[hdl/cle_ram.sv]
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/cle_ptr_alu.sv]
// shared pointer unit: pointers count modulo 2*depth, slot is pointer modulo depth
module cle_ptr_alu #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic [$clog2(2*BUFFER_DEPTH)-1:0] a,
  input  logic [$clog2(2*BUFFER_DEPTH)-1:0] b,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0] a_inc,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0] a_dec,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0] diff,
  output logic [$clog2(BUFFER_DEPTH)-1:0]   slot_a,
  output logic [$clog2(BUFFER_DEPTH)-1:0]   slot_dec
);

  localparam int PW  = $clog2(2*BUFFER_DEPTH);
  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int MOD = 2*BUFFER_DEPTH;

  logic [PW-1:0] slot_a_full;
  logic [PW-1:0] slot_dec_full;

  always_comb begin
    a_inc = (a == PW'(MOD-1)) ? '0 : a + PW'(1);
    a_dec = (a == '0) ? PW'(MOD-1) : a - PW'(1);
    // wraps correctly in PW bits whether or not MOD is a power of two
    diff  = (a >= b) ? a - b : a - b + PW'(MOD);
    slot_a_full   = (a >= PW'(BUFFER_DEPTH)) ? a - PW'(BUFFER_DEPTH) : a;
    slot_dec_full = (a_dec >= PW'(BUFFER_DEPTH)) ? a_dec - PW'(BUFFER_DEPTH) : a_dec;
    slot_a   = slot_a_full[AW-1:0];
    slot_dec = slot_dec_full[AW-1:0];
  end

endmodule

[hdl/console_line_editor.sv]
// console line editor: canonical terminal line discipline over a ring buffer
//
// in channel  : in_valid / in_stall / in_data. in_data.op selects receive of one
//               character or read of one committed byte. an item is taken when
//               in_valid is high and in_stall is low; in_stall stays high while
//               the sequencer works on the current item
// out channel : out_valid / out_stall / out_data. each result carries kind,
//               value, line_ready and last; last marks the final result of an item
// path        : a receive (echo or single erase) or an empty read goes from the item
//               register through ST_DECODE into the output register; a read that hits
//               the store passes ST_DECODE, ST_RD_WAIT and ST_RD_EMIT for the store read
// items       : one item at a time, the next is taken only back in ST_IDLE; a ^U
//               walk reads the store before each erased character
// reset       : rst_n (synchronous, active low) zeroes the read, commit and edit
//               pointers and empties the output register; the line store is not
//               cleared, only written entries are ever read
// stall       : a result waits in the output register while out_stall is high and
//               the sequencer holds until it can load the next one, no item lost
module console_line_editor
  import cle_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cle_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cle_out_t out_data
);

  localparam int PW = $clog2(2*BUFFER_DEPTH);
  localparam int AW = $clog2(BUFFER_DEPTH);

  // sequencer and pointer state
  cle_state_t    state_r, state_nxt;
  logic [PW-1:0] read_ptr_r, read_ptr_nxt;
  logic [PW-1:0] commit_ptr_r, commit_ptr_nxt;
  logic [PW-1:0] edit_ptr_r, edit_ptr_nxt;
  logic          pending_r, pending_nxt;   // one erase held back in a ^U walk
  cle_in_t       item_r;

  // output register
  logic     out_valid_r;
  cle_out_t out_data_r;
  logic     emit;
  cle_out_t emit_data;
  logic     out_free;

  // shared pointer unit
  logic [PW-1:0] alu_a, alu_inc, alu_dec, alu_diff;
  logic [AW-1:0] alu_slot, alu_slot_dec;

  // line store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // item decode
  logic       ch_ignore, ch_kill, ch_erase;
  logic [7:0] ch_stored;
  logic       buf_full, fill_commit, edit_at_commit, read_empty;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read items walk the read pointer, everything else the edit pointer
  assign alu_a = (item_r.op == OP_READ) ? read_ptr_r : edit_ptr_r;

  cle_ptr_alu #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_alu (
    .a        (alu_a),
    .b        (read_ptr_r),
    .a_inc    (alu_inc),
    .a_dec    (alu_dec),
    .diff     (alu_diff),
    .slot_a   (alu_slot),
    .slot_dec (alu_slot_dec)
  );

  cle_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ch_ignore = (item_r.char_in == CH_NUL) || (item_r.char_in == CH_NONE) ||
                (item_r.char_in == CH_CTRL_P);
    ch_kill   = (item_r.char_in == CH_CTRL_U);
    ch_erase  = (item_r.char_in == CH_CTRL_H) || (item_r.char_in == CH_DEL);
    ch_stored = (item_r.char_in == CH_CR) ? CH_NL : item_r.char_in;
    // fill level is edit minus read; full when it reaches the depth
    buf_full       = (alu_diff >= PW'(BUFFER_DEPTH));
    fill_commit    = (alu_diff == PW'(BUFFER_DEPTH-1));
    edit_at_commit = (edit_ptr_r == commit_ptr_r);
    read_empty     = (read_ptr_r == commit_ptr_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (item_r.op == OP_READ) begin
          if (!read_empty)   state_nxt = ST_RD_WAIT;
          else if (out_free) state_nxt = ST_IDLE;
        end else begin
          priority if (ch_ignore) begin
            state_nxt = ST_IDLE;
          end else if (ch_kill) begin
            state_nxt = ST_KILL_CHK;
          end else if (ch_erase) begin
            if (edit_at_commit || out_free) state_nxt = ST_IDLE;
          end else begin
            if (buf_full || out_free) state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD_WAIT: begin
        state_nxt = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_KILL_CHK: begin
        if (!edit_at_commit)            state_nxt = ST_KILL_WAIT;
        else if (!pending_r || out_free) state_nxt = ST_IDLE;
      end
      ST_KILL_WAIT: begin
        state_nxt = ST_KILL_EVAL;
      end
      ST_KILL_EVAL: begin
        if (ram_rdata == CH_NL) begin
          if (!pending_r || out_free) state_nxt = ST_IDLE;
        end else begin
          if (!pending_r || out_free) state_nxt = ST_KILL_CHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result payload
  always_comb begin
    emit           = 1'b0;
    emit_data      = '{kind: K_ECHO, value: 8'h00, line_ready: 1'b0, last: 1'b1};
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    edit_ptr_nxt   = edit_ptr_r;
    pending_nxt    = pending_r;
    ram_we         = 1'b0;
    ram_waddr      = alu_slot;
    ram_wdata      = ch_stored;
    ram_re         = 1'b0;
    ram_raddr      = alu_slot;
    unique case (state_r)
      ST_IDLE: begin
        pending_nxt = 1'b0;
      end
      ST_DECODE: begin
        if (item_r.op == OP_READ) begin
          if (read_empty) begin
            emit           = out_free;
            emit_data.kind = K_EMPTY;
          end else begin
            ram_re = 1'b1;
          end
        end else if (ch_ignore || ch_kill) begin
          // kill walk starts in its own states
        end else if (ch_erase) begin
          if (!edit_at_commit && out_free) begin
            emit           = 1'b1;
            emit_data.kind = K_ERASE;
            edit_ptr_nxt   = alu_dec;
          end
        end else if (!buf_full && out_free) begin
          // store, echo and maybe commit the line
          emit            = 1'b1;
          emit_data.kind  = K_ECHO;
          emit_data.value = ch_stored;
          ram_we          = 1'b1;
          edit_ptr_nxt    = alu_inc;
          if (ch_stored == CH_NL || ch_stored == CH_CTRL_D || fill_commit) begin
            commit_ptr_nxt       = alu_inc;
            emit_data.line_ready = 1'b1;
          end
        end
      end
      ST_RD_WAIT: begin
      end
      ST_RD_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (ram_rdata == CH_CTRL_D) begin
            // ^D stays for the next read unless it opens this one
            emit_data.kind = K_EOF;
            if (item_r.first_of_read) read_ptr_nxt = alu_inc;
          end else begin
            emit_data.kind  = K_DATA;
            emit_data.value = ram_rdata;
            read_ptr_nxt    = alu_inc;
          end
        end
      end
      ST_KILL_CHK: begin
        ram_raddr = alu_slot_dec;
        if (!edit_at_commit) begin
          ram_re = 1'b1;
        end else if (pending_r && out_free) begin
          emit           = 1'b1;
          emit_data.kind = K_ERASE;
          pending_nxt    = 1'b0;
        end
      end
      ST_KILL_WAIT: begin
      end
      ST_KILL_EVAL: begin
        if (ram_rdata == CH_NL) begin
          if (pending_r && out_free) begin
            emit           = 1'b1;
            emit_data.kind = K_ERASE;
            pending_nxt    = 1'b0;
          end
        end else if (!pending_r || out_free) begin
          // flush the held erase as not last, hold this one back
          emit           = pending_r;
          emit_data.kind = K_ERASE;
          emit_data.last = 1'b0;
          pending_nxt    = 1'b1;
          edit_ptr_nxt   = alu_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      edit_ptr_r   <= '0;
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_ptr_r   <= read_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      edit_ptr_r   <= edit_ptr_nxt;
      pending_r    <= pending_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
    if (emit)                  out_data_r <= emit_data;
  end

endmodule

[hdl/cle_checker.sv]
module cle_checker
  import cle_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input cle_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input cle_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one in work");

  // only an echo can commit a line
  a_ready_on_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != K_ECHO |-> !out_data.line_ready)
    else $error("line_ready on non-echo result");

  // echo and read results are single results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_ECHO || out_data.kind == K_DATA ||
                  out_data.kind == K_EOF || out_data.kind == K_EMPTY)
    |-> out_data.last)
    else $error("single result without last");

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);
